FILE: hdl/printhead_temp_calib_correct_defines.svh
// ----------------------------------------------------------------------------
// printhead temp calib correct assertion macros
// shared property forms for the correction block checks
// ----------------------------------------------------------------------------
`ifndef PRINTHEAD_TEMP_CALIB_CORRECT_DEFINES_SVH
`define PRINTHEAD_TEMP_CALIB_CORRECT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define PTCC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PTCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ptcc_pkg.sv
// ----------------------------------------------------------------------------
// ptcc_pkg
// shared constants, command types and divider tables of the correction block
// ----------------------------------------------------------------------------
`default_nettype none

package ptcc_pkg;

   // field widths
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned DPI_W     = 9;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned POS_W     = 14;
   localparam int unsigned REL_W     = 12;
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned ACC_W     = 32;
   localparam int unsigned QUOT_W    = 16;
   localparam int unsigned DIVISOR_W = 20;
   localparam int unsigned RECIP_W   = 26;
   localparam int unsigned DELTA_W   = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REF_TEMP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_TEMP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DPI      = 2'd2;

   // blob layout
   localparam logic [POS_W-1:0] MEAS_BYTES    = 14'd12337;
   localparam int unsigned      GROUP_BYTES   = 2056;
   localparam int unsigned      CHANNEL_BYTES = 514;
   localparam int unsigned      WORD_AREA     = 256;

   // resolutions and temperature window
   localparam logic [DPI_W-1:0] DPI_HIGH   = 9'd360;
   localparam logic [DPI_W-1:0] DPI_MID    = 9'd180;
   localparam logic [DPI_W-1:0] DPI_LOW    = 9'd90;
   localparam logic [DPI_W-1:0] TEMP_LIMIT = 9'd10;

   // correction factors
   localparam logic [5:0]  RATE_CH1   = 6'd50;
   localparam logic [5:0]  RATE_CH2   = 6'd20;
   localparam logic [15:0] FACTOR_CH1 = 16'd50000;
   localparam logic [15:0] FACTOR_CH2 = 16'd20000;
   localparam logic [6:0]  PCT_CH1    = 7'd81;
   localparam logic [6:0]  PCT_OTHER  = 7'd82;
   localparam logic [16:0] ADJ_ROUND  = 17'd64;

   // reciprocal divide: q ~ (a * floor(2^shift / d)) >> shift, one fix-up
   localparam int unsigned RECIP_SHIFT = 32;
   localparam logic [63:0] RECIP_ONE   = 64'd1 << RECIP_SHIFT;
   localparam logic [DIVISOR_W-1:0] DIV_D_TEMP   = 20'd10000;
   localparam logic [DIVISOR_W-1:0] DIV_D_OFFSET = 20'd998400;
   localparam logic [DIVISOR_W-1:0] DIV_D_SCALE  = 20'd100;
   localparam logic [63:0] DIV_K_TEMP_W   = RECIP_ONE / 64'd10000;
   localparam logic [63:0] DIV_K_OFFSET_W = RECIP_ONE / 64'd998400;
   localparam logic [63:0] DIV_K_SCALE_W  = RECIP_ONE / 64'd100;
   localparam logic [RECIP_W-1:0] DIV_K_TEMP   = DIV_K_TEMP_W[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] DIV_K_OFFSET = DIV_K_OFFSET_W[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] DIV_K_SCALE  = DIV_K_SCALE_W[RECIP_W-1:0];

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_MUL_RATE,
      OP_MUL_DELTA,
      OP_MUL_FACTOR,
      OP_ABS,
      OP_MUL_PCT,
      OP_RECIP,
      OP_BACK,
      OP_FIX
   } dp_op_type;

   typedef enum logic [1:0] {
      DIV_TEMP,
      DIV_OFFSET,
      DIV_SCALE
   } div_sel_type;

   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_ONE,
      OUT_HI,
      OUT_LO
   } out_sel_type;

   typedef struct packed {
      logic                take;
      logic                load_le;
      dp_op_type           op;
      div_sel_type         div_sel;
      logic                chan_one;
      logic [DELTA_W-1:0]  delta_mag;
      logic                delta_neg;
      out_sel_type         out_sel;
   } dp_cmd_type;

   function automatic logic [DIVISOR_W-1:0] div_divisor(input div_sel_type sel);
      logic [DIVISOR_W-1:0] d;
      case (sel)
         DIV_TEMP:   d = DIV_D_TEMP;
         DIV_OFFSET: d = DIV_D_OFFSET;
         default:    d = DIV_D_SCALE;
      endcase
      return d;
   endfunction

   function automatic logic [RECIP_W-1:0] div_recip(input div_sel_type sel);
      logic [RECIP_W-1:0] k;
      case (sel)
         DIV_TEMP:   k = DIV_K_TEMP;
         DIV_OFFSET: k = DIV_K_OFFSET;
         default:    k = DIV_K_SCALE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/ptcc_if.sv
// ----------------------------------------------------------------------------
// ptcc channel interfaces
// valid/ready channels for blob bytes, table bytes and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface ptcc_req_if;
   import ptcc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;
   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface ptcc_rsp_if;
   import ptcc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;
   logic              status;
   modport source (output valid, output out_byte, output last_byte, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input last_byte, input status,
                   output ready);
endinterface

interface ptcc_csr_if;
   import ptcc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DPI_W-1:0]     wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: hdl/ptcc_datapath.sv
// ----------------------------------------------------------------------------
// ptcc_datapath
// word assembly, multipliers, reciprocal divider and table byte select
// ----------------------------------------------------------------------------
`default_nettype none

module ptcc_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ptcc_pkg::BYTE_W-1:0]  data_byte,
   input  ptcc_pkg::dp_cmd_type         cmd,
   output logic [ptcc_pkg::BYTE_W-1:0]  out_byte
);
   import ptcc_pkg::*;

   logic [BYTE_W-1:0]  hi_ff,   hi_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [ACC_W-1:0]   acc_ff,  acc_in;
   logic               neg_ff,  neg_in;
   logic [QUOT_W-1:0]  qt_ff,   qt_in;
   logic [ACC_W-1:0]   back_ff, back_in;

   logic [5:0]              rate;
   logic [15:0]             factor;
   logic [6:0]              pct;
   logic [DIVISOR_W-1:0]    divisor;
   logic [RECIP_W-1:0]      recip;
   logic [21:0]             rate_prod;
   logic [25:0]             delta_prod;
   logic [32:0]             factor_prod;
   logic [22:0]             pct_prod;
   logic [ACC_W+RECIP_W-1:0] recip_prod;
   logic [QUOT_W+DIVISOR_W-1:0] back_prod;
   logic [ACC_W-1:0]        negated;
   logic [ACC_W-1:0]        remainder;
   logic [QUOT_W-1:0]       quot;
   logic [QUOT_W-1:0]       quot_signed;

   assign rate    = cmd.chan_one ? RATE_CH1   : RATE_CH2;
   assign factor  = cmd.chan_one ? FACTOR_CH1 : FACTOR_CH2;
   assign pct     = cmd.chan_one ? PCT_CH1    : PCT_OTHER;
   assign divisor = div_divisor(cmd.div_sel);
   assign recip   = div_recip(cmd.div_sel);

   assign rate_prod   = 22'(word_ff) * 22'(rate);
   assign delta_prod  = 26'(acc_ff[21:0]) * 26'(cmd.delta_mag);
   assign factor_prod = 33'({1'b0, word_ff} + ADJ_ROUND) * 33'(factor);
   assign pct_prod    = 23'(word_ff) * 23'(pct);
   assign recip_prod  = (ACC_W+RECIP_W)'(acc_ff) * (ACC_W+RECIP_W)'(recip);
   assign back_prod   = (QUOT_W+DIVISOR_W)'(qt_ff) * (QUOT_W+DIVISOR_W)'(divisor);

   // negative of the wrapped product, taken as a signed 32-bit value
   assign negated     = ACC_W'(0) - acc_ff;
   assign remainder   = acc_ff - back_ff;
   assign quot        = qt_ff + QUOT_W'(remainder >= ACC_W'(divisor));
   assign quot_signed = neg_ff ? (QUOT_W'(0) - quot) : quot;

   always_comb begin
      hi_in   = hi_ff;
      word_in = word_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      qt_in   = qt_ff;
      back_in = back_ff;
      if (cmd.take) begin
         hi_in   = data_byte;
         word_in = cmd.load_le ? {data_byte, hi_ff} : {hi_ff, data_byte};
      end
      unique case (cmd.op)
         OP_IDLE: begin
         end
         OP_MUL_RATE: begin
            acc_in = ACC_W'(rate_prod);
         end
         OP_MUL_DELTA: begin
            acc_in = ACC_W'(delta_prod);
            neg_in = cmd.delta_neg;
         end
         OP_MUL_FACTOR: begin
            acc_in = factor_prod[ACC_W-1:0];
         end
         OP_ABS: begin
            neg_in = negated[ACC_W-1];
            acc_in = negated[ACC_W-1] ? acc_ff : negated;
         end
         OP_MUL_PCT: begin
            acc_in = ACC_W'(pct_prod);
            neg_in = 1'b0;
         end
         OP_RECIP: begin
            qt_in = recip_prod[RECIP_SHIFT +: QUOT_W];
         end
         OP_BACK: begin
            back_in = back_prod[ACC_W-1:0];
         end
         OP_FIX: begin
            case (cmd.div_sel)
               DIV_TEMP:   word_in = word_ff - quot_signed;
               DIV_OFFSET: word_in = word_ff + quot_signed;
               default:    word_in = quot;
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (cmd.out_sel)
         OUT_ZERO: out_byte = '0;
         OUT_ONE:  out_byte = BYTE_W'(1);
         OUT_HI:   out_byte = word_ff[WORD_W-1 -: BYTE_W];
         OUT_LO:   out_byte = word_ff[BYTE_W-1:0];
         default:  out_byte = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
      end else begin
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      qt_ff   <= qt_in;
      back_ff <= back_in;
   end

endmodule

`default_nettype wire

FILE: hdl/ptcc_ctrl.sv
// ----------------------------------------------------------------------------
// ptcc_ctrl
// registers, blob position tracking, byte classification and sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module ptcc_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_frame_start,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_last,
   output logic                            rsp_status,
   input  logic                            csr_valid,
   input  logic [ptcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptcc_pkg::DPI_W-1:0]      csr_wdata,
   output logic                            csr_ready,
   output ptcc_pkg::dp_cmd_type            cmd
);
   import ptcc_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE       = 11'b000_0000_0001,
      ST_MUL_RATE   = 11'b000_0000_0010,
      ST_MUL_DELTA  = 11'b000_0000_0100,
      ST_MUL_FACTOR = 11'b000_0000_1000,
      ST_ABS        = 11'b000_0001_0000,
      ST_MUL_PCT    = 11'b000_0010_0000,
      ST_RECIP      = 11'b000_0100_0000,
      ST_BACK       = 11'b000_1000_0000,
      ST_FIX        = 11'b001_0000_0000,
      ST_OUT_HI     = 11'b010_0000_0000,
      ST_OUT_LO     = 11'b100_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_REJECT,
      KIND_HEAD,
      KIND_PASS,
      KIND_SCALE,
      KIND_TEMP,
      KIND_OFFSET
   } kind_type;

   localparam logic [POS_W-1:0] BASE_G0   = POS_W'(1);
   localparam logic [POS_W-1:0] BASE_G1   = POS_W'(1 + GROUP_BYTES);
   localparam logic [POS_W-1:0] BASE_G2   = POS_W'(1 + 2 * GROUP_BYTES);
   localparam logic [POS_W-1:0] GROUP_LEN = POS_W'(GROUP_BYTES);
   localparam logic [REL_W-1:0] REL_LAST  = REL_W'(GROUP_BYTES - 1);
   localparam logic [REL_W-1:0] CH1_START = REL_W'(CHANNEL_BYTES);
   localparam logic [REL_W-1:0] CH2_START = REL_W'(2 * CHANNEL_BYTES);
   localparam logic [REL_W-1:0] CH3_START = REL_W'(3 * CHANNEL_BYTES);
   localparam logic [REL_W-1:0] WORD_END  = REL_W'(WORD_AREA);

   state_type         state_ff,   state_in;
   kind_type          kind_ff,    kind_in;
   div_sel_type       div_sel_ff, div_sel_in;
   logic              last_ff,    last_in;
   logic              chan_one_ff, chan_one_in;
   logic [POS_W-1:0]  pos_ff,     pos_in;
   logic              rejected_ff, rejected_in;
   logic [BYTE_W-1:0] ref_temp_ff, ref_temp_in;
   logic [BYTE_W-1:0] cur_temp_ff, cur_temp_in;
   logic [DPI_W-1:0]  dpi_ff,     dpi_in;

   logic              accept;
   logic [DPI_W-1:0]  delta_raw;
   logic              delta_neg;
   logic [DPI_W-1:0]  delta_abs;
   logic              cfg_ok;
   logic [POS_W-1:0]  pos_eff;
   logic              in_range;
   logic [POS_W-1:0]  base;
   logic [POS_W-1:0]  rel_full;
   logic              in_group;
   logic [REL_W-1:0]  rel;
   logic [REL_W-1:0]  word_idx;
   logic [REL_W-1:0]  off;
   logic              chan_one;
   logic              chan_mid;
   kind_type          item_kind;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // live temperature and resolution check
   assign delta_raw = {1'b0, cur_temp_ff} - {1'b0, ref_temp_ff};
   assign delta_neg = delta_raw[DPI_W-1];
   assign delta_abs = delta_neg ? (DPI_W'(0) - delta_raw) : delta_raw;
   assign cfg_ok    = (delta_abs <= TEMP_LIMIT)
                   && (dpi_ff == DPI_HIGH || dpi_ff == DPI_MID || dpi_ff == DPI_LOW);

   always_comb begin
      unique case (dpi_ff)
         DPI_HIGH: base = BASE_G0;
         DPI_MID:  base = BASE_G1;
         default:  base = BASE_G2;
      endcase
   end

   assign pos_eff  = req_frame_start ? '0 : pos_ff;
   assign in_range = pos_eff < MEAS_BYTES;
   assign rel_full = pos_eff - base;
   assign in_group = (pos_eff >= base) && (rel_full < GROUP_LEN);
   assign rel      = rel_full[REL_W-1:0];
   assign word_idx = rel - REL_W'(1);
   assign chan_one = (word_idx >= CH1_START) && (word_idx < CH2_START);
   assign chan_mid = (word_idx >= CH1_START) && (word_idx < CH3_START);

   always_comb begin
      if (word_idx < CH1_START) begin
         off = word_idx;
      end else if (word_idx < CH2_START) begin
         off = word_idx - CH1_START;
      end else if (word_idx < CH3_START) begin
         off = word_idx - CH2_START;
      end else begin
         off = word_idx - CH3_START;
      end
   end

   always_comb begin
      item_kind = KIND_NONE;
      if (!in_range) begin
         item_kind = KIND_NONE;
      end else if (pos_eff == '0) begin
         item_kind = cfg_ok ? KIND_NONE : KIND_REJECT;
      end else if (rejected_ff || !cfg_ok || !in_group) begin
         item_kind = KIND_NONE;
      end else if (!rel[0]) begin
         item_kind = (rel == '0) ? KIND_HEAD : KIND_NONE;
      end else if (off < WORD_END) begin
         item_kind = chan_mid ? KIND_TEMP : KIND_SCALE;
      end else if (off == WORD_END && chan_mid) begin
         item_kind = KIND_OFFSET;
      end else begin
         item_kind = KIND_PASS;
      end
   end

   always_comb begin
      ref_temp_in = ref_temp_ff;
      cur_temp_in = cur_temp_ff;
      dpi_in      = dpi_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REF_TEMP: ref_temp_in = csr_wdata[BYTE_W-1:0];
            CSR_CUR_TEMP: cur_temp_in = csr_wdata[BYTE_W-1:0];
            CSR_DPI:      dpi_in      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      div_sel_in  = div_sel_ff;
      last_in     = last_ff;
      chan_one_in = chan_one_ff;
      pos_in      = pos_ff;
      rejected_in = rejected_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               pos_in      = pos_eff + POS_W'(1);
               kind_in     = item_kind;
               last_in     = (rel == REL_LAST);
               chan_one_in = chan_one;
               if (pos_eff == '0) begin
                  rejected_in = !cfg_ok;
               end
               case (item_kind)
                  KIND_REJECT, KIND_HEAD: state_in = ST_OUT_LO;
                  KIND_PASS:   state_in = ST_OUT_HI;
                  KIND_SCALE: begin
                     state_in   = ST_MUL_PCT;
                     div_sel_in = DIV_SCALE;
                  end
                  KIND_TEMP: begin
                     state_in   = ST_MUL_RATE;
                     div_sel_in = DIV_TEMP;
                  end
                  KIND_OFFSET: begin
                     state_in   = ST_MUL_FACTOR;
                     div_sel_in = DIV_OFFSET;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL_RATE:   state_in = ST_MUL_DELTA;
         ST_MUL_DELTA:  state_in = ST_RECIP;
         ST_MUL_FACTOR: state_in = ST_ABS;
         ST_ABS:        state_in = ST_RECIP;
         ST_MUL_PCT:    state_in = ST_RECIP;
         ST_RECIP:      state_in = ST_BACK;
         ST_BACK:       state_in = ST_FIX;
         ST_FIX: begin
            // temperature pass is followed by the percent scale
            if (div_sel_ff == DIV_TEMP) begin
               state_in   = ST_MUL_PCT;
               div_sel_in = DIV_SCALE;
            end else begin
               state_in = ST_OUT_HI;
            end
         end
         ST_OUT_HI: begin
            if (rsp_ready) begin
               state_in = ST_OUT_LO;
            end
         end
         ST_OUT_LO: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.take      = accept && in_range;
      cmd.load_le   = (item_kind == KIND_OFFSET);
      cmd.div_sel   = div_sel_ff;
      cmd.chan_one  = chan_one_ff;
      cmd.delta_mag = delta_abs[DELTA_W-1:0];
      cmd.delta_neg = delta_neg;
      cmd.op        = OP_IDLE;
      cmd.out_sel   = OUT_ZERO;
      unique case (state_ff)
         ST_MUL_RATE:   cmd.op = OP_MUL_RATE;
         ST_MUL_DELTA:  cmd.op = OP_MUL_DELTA;
         ST_MUL_FACTOR: cmd.op = OP_MUL_FACTOR;
         ST_ABS:        cmd.op = OP_ABS;
         ST_MUL_PCT:    cmd.op = OP_MUL_PCT;
         ST_RECIP:      cmd.op = OP_RECIP;
         ST_BACK:       cmd.op = OP_BACK;
         ST_FIX:        cmd.op = OP_FIX;
         ST_OUT_HI: begin
            // adjusted word leaves low byte first, and its low byte is masked off
            cmd.out_sel = (kind_ff == KIND_OFFSET) ? OUT_ZERO : OUT_HI;
         end
         ST_OUT_LO: begin
            case (kind_ff)
               KIND_REJECT: cmd.out_sel = OUT_ZERO;
               KIND_HEAD:   cmd.out_sel = OUT_ONE;
               KIND_OFFSET: cmd.out_sel = OUT_HI;
               default:     cmd.out_sel = OUT_LO;
            endcase
         end
         default: cmd.op = OP_IDLE;
      endcase
   end

   assign rsp_valid  = (state_ff == ST_OUT_HI) || (state_ff == ST_OUT_LO);
   assign rsp_status = (state_ff == ST_OUT_LO) && (kind_ff == KIND_REJECT);
   assign rsp_last   = (state_ff == ST_OUT_LO) && ((kind_ff == KIND_REJECT) || last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         kind_ff     <= KIND_NONE;
         div_sel_ff  <= DIV_SCALE;
         last_ff     <= 1'b0;
         chan_one_ff <= 1'b0;
         pos_ff      <= '0;
         rejected_ff <= 1'b0;
         ref_temp_ff <= '0;
         cur_temp_ff <= '0;
         dpi_ff      <= DPI_HIGH;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         div_sel_ff  <= div_sel_in;
         last_ff     <= last_in;
         chan_one_ff <= chan_one_in;
         pos_ff      <= pos_in;
         rejected_ff <= rejected_in;
         ref_temp_ff <= ref_temp_in;
         cur_temp_ff <= cur_temp_in;
         dpi_ff      <= dpi_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/printhead_temp_calib_correct.sv
// ----------------------------------------------------------------------------
// printhead_temp_calib_correct
// Streams a calibration blob in one byte per word and returns the temperature
// corrected table for the selected resolution. The first blob byte is checked
// against the live registers: a bad resolution or a temperature difference
// beyond ten gives a single rejection word (zero byte, last and status set)
// and the rest of that blob gives nothing. Otherwise the table opens with a
// byte of one, followed by the 2056 bytes of the group picked by the
// resolution (360, 180, 90 dpi). Bytes are paired; both table bytes of a pair
// leave after the pair's second byte. The block works on one input word at a
// time, sequenced by one shared reciprocal divider (multiply, back-multiply,
// fix-up) and a small set of registered multipliers. A word that is only
// scaled goes through the divider once, as does the offset-word adjust; a
// word with both the temperature and the percent scale makes two passes
// through the divider. The next input byte is taken only after the table
// bytes of the last one have left. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "printhead_temp_calib_correct_defines.svh"

module printhead_temp_calib_correct (
   input  logic        clock,
   input  logic        reset,
   ptcc_req_if.sink    req_if,
   ptcc_rsp_if.source  rsp_if,
   ptcc_csr_if.sink    csr_if
);
   import ptcc_pkg::*;

   // command word from the sequencer into the datapath
   dp_cmd_type        cmd;
   logic              req_ready;
   logic              rsp_valid;
   logic              rsp_last;
   logic              rsp_status;
   logic              csr_ready;
   logic [BYTE_W-1:0] table_byte;

   // sequencer: registers, position in the blob, byte classes, step order
   ptcc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_frame_start (req_if.frame_start),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_if.valid),
      .csr_index       (csr_if.index),
      .csr_wdata       (csr_if.wdata),
      .csr_ready       (csr_ready),
      .cmd             (cmd)
   );

   // datapath: pending high byte, word register, multipliers and divider
   ptcc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_if.data_byte),
      .cmd       (cmd),
      .out_byte  (table_byte)
   );

   // channel hookup
   assign req_if.ready     = req_ready;
   assign csr_if.ready     = csr_ready;
   assign rsp_if.valid     = rsp_valid;
   assign rsp_if.out_byte  = table_byte;
   assign rsp_if.last_byte = rsp_last;
   assign rsp_if.status    = rsp_status;

   // one word in flight: input stays closed while a table byte is offered
   `PTCC_ASSERT_SAME(a_rsp_blocks_req, rsp_if.valid, !req_if.ready, "input open while table byte pending")
   // a rejection is always a single closing zero byte
   `PTCC_ASSERT_SAME(a_reject_form, rsp_if.valid && rsp_if.status, rsp_if.last_byte && (rsp_if.out_byte == '0), "malformed rejection word")
   // after the closing byte of a word the input opens again
   `PTCC_ASSERT_NEXT(a_last_frees_input, rsp_if.valid && rsp_if.ready && rsp_if.last_byte, req_if.ready, "input not reopened after closing byte")

endmodule

`default_nettype wire

FILE: tb/sv/ptcc_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptcc_table_checker
// Watches the blob, table and register channels of the correction block.
// Keeps its own copy of the registers and blob state, predicts the table
// bytes of every accepted blob byte and compares them in order.
// ----------------------------------------------------------------------------

module ptcc_table_checker
   import ptcc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ptcc_req_if  req_if,
   ptcc_rsp_if  rsp_if,
   ptcc_csr_if  csr_if,
   output int   mismatch_count,
   output int   bytes_pending
);

   localparam int          BLOB_LIMIT  = 12337;
   localparam int          GRP_BYTES   = 2056;
   localparam int          CHAN_BYTES  = 514;
   localparam int          WORD_BYTES  = 256;
   localparam int          TEMP_SPAN   = 10;
   localparam int          TEMP_DIV    = 10000;
   localparam int          OFFSET_DIV  = 998400;
   localparam int          OFFSET_BIAS = 64;
   localparam logic [15:0] OFFSET_MASK = 16'hff00;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
      logic              rejected;
   } table_byte_t;

   table_byte_t       table_q[$];
   table_byte_t       want;
   int                errors = 0;

   logic [BYTE_W-1:0] ref_temp;
   logic [BYTE_W-1:0] cur_temp;
   logic [DPI_W-1:0]  dpi;
   logic [POS_W-1:0]  blob_pos;
   logic [BYTE_W-1:0] prev_byte;
   logic              blob_bad;

   function automatic void expect_byte(input logic [7:0] v, input logic last,
                                       input logic rej);
      table_byte_t e;
      e.value    = v;
      e.last     = last;
      e.rejected = rej;
      table_q.push_back(e);
   endfunction

   // table bytes caused by one blob byte, registers read live
   task automatic predict_table_bytes(input logic [7:0] b, input logic start);
      int          delta;
      bit          settings_ok;
      int          base;
      int          pos;
      int          rel;
      int          chan;
      int          offs;
      int          word_val;
      int          change;
      int          sum;
      int          adj;
      bit          at_end;
      logic [7:0]  hi;
      logic [15:0] word16;
      logic [31:0] prod;
      delta = int'(cur_temp) - int'(ref_temp);
      settings_ok = (dpi == DPI_HIGH || dpi == DPI_MID || dpi == DPI_LOW)
                    && delta >= -TEMP_SPAN && delta <= TEMP_SPAN;
      base = 1 + GRP_BYTES * ((dpi == DPI_HIGH) ? 0 : (dpi == DPI_MID) ? 1 : 2);
      if (start) blob_pos = '0;
      if (int'(blob_pos) >= BLOB_LIMIT) return;
      pos = int'(blob_pos);
      blob_pos = blob_pos + 1'b1;
      hi = prev_byte;
      prev_byte = b;
      if (pos == 0) begin
         blob_bad = !settings_ok;
         if (!settings_ok) expect_byte(8'h00, 1'b1, 1'b1);
         return;
      end
      if (blob_bad || !settings_ok || pos < base || pos - base >= GRP_BYTES) return;
      rel = pos - base;
      at_end = (rel == GRP_BYTES - 1);
      if (rel % 2 == 0) begin
         // header byte on the group's first byte, else first half of a pair
         if (rel == 0) expect_byte(8'h01, 1'b0, 1'b0);
         return;
      end
      chan = (rel - 1) / CHAN_BYTES;
      offs = (rel - 1) % CHAN_BYTES;
      if (offs < WORD_BYTES) begin
         word_val = int'({hi, b});
         if (chan == 1 || chan == 2) begin
            change = delta * word_val * ((chan == 1) ? 50 : 20) / TEMP_DIV;
            sum = word_val - change;
            word16 = sum[15:0];
            word_val = int'(word16);
         end
         word_val = word_val * ((chan == 1) ? 81 : 82) / 100;
         word16 = word_val[15:0];
         expect_byte(word16[15:8], 1'b0, 1'b0);
         expect_byte(word16[7:0], at_end, 1'b0);
      end else if (offs == WORD_BYTES && (chan == 1 || chan == 2)) begin
         // little-endian offset word, product wraps at 32 bits
         prod = ({16'h0, b, hi} + 32'(OFFSET_BIAS))
                * (32'd0 - ((chan == 1) ? 32'd50000 : 32'd20000));
         adj = $signed(prod) / OFFSET_DIV;
         sum = int'({b, hi}) + adj;
         word16 = sum[15:0] & OFFSET_MASK;
         expect_byte(word16[7:0], 1'b0, 1'b0);
         expect_byte(word16[15:8], at_end, 1'b0);
      end else begin
         expect_byte(hi, 1'b0, 1'b0);
         expect_byte(b, at_end, 1'b0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ref_temp  = '0;
         cur_temp  = '0;
         dpi       = DPI_HIGH;
         blob_pos  = '0;
         prev_byte = '0;
         blob_bad  = 1'b0;
         table_q.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_REF_TEMP: ref_temp = csr_if.wdata[BYTE_W-1:0];
               CSR_CUR_TEMP: cur_temp = csr_if.wdata[BYTE_W-1:0];
               CSR_DPI:      dpi = csr_if.wdata;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            predict_table_bytes(req_if.data_byte, req_if.frame_start);
         if (rsp_if.valid && rsp_if.ready) begin
            if (table_q.size() == 0) begin
               $error("table word %02h last %0b status %0b with nothing expected",
                      rsp_if.out_byte, rsp_if.last_byte, rsp_if.status);
               errors++;
            end else begin
               want = table_q.pop_front();
               if (rsp_if.out_byte !== want.value) begin
                  $error("out_byte expected %02h got %02h", want.value, rsp_if.out_byte);
                  errors++;
               end
               if (rsp_if.last_byte !== want.last) begin
                  $error("last_byte expected %0b got %0b", want.last, rsp_if.last_byte);
                  errors++;
               end
               if (rsp_if.status !== want.rejected) begin
                  $error("status expected %0b got %0b", want.rejected, rsp_if.status);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      bytes_pending  <= table_q.size();
   end

endmodule

FILE: tb/sv/printhead_temp_calib_correct_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// printhead_temp_calib_correct_tb
// Drives measurement blobs and register settings into the correction block
// and leaves prediction and comparison of the table bytes to the checker.
// A directed part covers reset defaults, rejections, full groups for every
// resolution, an overlong blob and settings changed inside a blob; random
// blobs with random settings follow under two idling patterns.
// ----------------------------------------------------------------------------

module printhead_temp_calib_correct_tb;
   import ptcc_pkg::*;

   localparam int SETTLE_CYCLES    = 24;       // margin past the longest word, one with two divider passes
   localparam int CYCLE_LIMIT      = 3000000;
   localparam int RANDOM_BYTES     = 1000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int FULL_BLOB        = 2057;     // byte zero plus one group

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct = 14;
   int   recv_idle_pct = 76;
   bit   long_hold_due = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count;
   int   bytes_pending;
   int   random_bytes;
   bit   table_on;

   ptcc_req_if req_ch ();
   ptcc_rsp_if rsp_ch ();
   ptcc_csr_if csr_ch ();

   printhead_temp_calib_correct uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   ptcc_table_checker table_check (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch),
      .csr_if         (csr_ch),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // table side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_due = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // blob content leaning on the extremes now and then
   function automatic logic [7:0] blob_byte();
      case ($urandom_range(15))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // one blob word, held until the block takes it
   task automatic send_byte(input logic [7:0] b, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.frame_start <= start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // stray starts inject restarts in the middle of a blob
   task automatic send_blob(input int len, input bit with_start, input bit stray_starts);
      bit s;
      for (int i = 0; i < len; i++) begin
         s = (i == 0) ? with_start : (stray_starts && $urandom_range(199) == 0);
         send_byte(blob_byte(), s);
      end
   endtask

   // valid is left high between writes, lowered once by set_config
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DPI_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] r, input logic [7:0] c,
                             input logic [DPI_W-1:0] d);
      write_reg(CSR_REF_TEMP, {1'b0, r});
      write_reg(CSR_CUR_TEMP, {1'b0, c});
      write_reg(CSR_DPI, d);
      csr_ch.valid <= 1'b0;
   endtask

   // block idle: every expected word seen, then time for bytes that give nothing
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed settings at 360 dpi, some other groups and some junk
   task automatic random_settings(output bit produces);
      logic [7:0]       r;
      logic [7:0]       c;
      logic [DPI_W-1:0] d;
      int               k;
      int               delta;
      k = $urandom_range(99);
      d = (k < 80) ? DPI_HIGH : (k < 88) ? DPI_MID : (k < 93) ? DPI_LOW
                                                          : 9'($urandom_range(511));
      r = 8'($urandom_range(245, 10));
      c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(int'(r) + $urandom_range(20) - 10);
      delta = int'(c) - int'(r);
      produces = (d == DPI_HIGH) && delta >= -10 && delta <= 10;
      set_config(r, c, d);
   endtask

   function automatic int random_blob_len();
      int k;
      k = $urandom_range(99);
      if (k < 8)  return $urandom_range(5, 1);
      if (k < 70) return $urandom_range(60, 2);
      if (k < 92) return $urandom_range(600, 60);
      return $urandom_range(2100, 600);
   endfunction

   // well-formed blobs with random content, a few stray restarts as noise
   task automatic random_blobs(input int target);
      int len;
      while (random_bytes < target) begin
         wait_drained();
         random_settings(table_on);
         len = random_blob_len();
         send_blob(len, ($urandom_range(19) != 0), ($urandom_range(9) == 0));
         if (table_on) random_bytes += len;
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = '0;
      req_ch.frame_start = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_REF_TEMP;
      csr_ch.wdata       = '0;
      random_bytes       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, sender idles 14 percent, receiver 76 ----

      // no frame_start after reset: first word counts as byte zero,
      // reset settings (360 dpi, both temps zero) are valid
      send_blob(40, 1'b0, 1'b0);
      wait_drained();

      // largest positive difference, whole group 0 plus bytes past it
      set_config(8'd0, 8'd10, DPI_HIGH);
      send_blob(FULL_BLOB + 3, 1'b1, 1'b0);
      wait_drained();

      // rejections: difference one past the window either way
      set_config(8'd0, 8'd11, DPI_HIGH);
      send_blob(4, 1'b1, 1'b0);
      wait_drained();
      // settings turn good again, but a rejected blob stays silent
      set_config(8'd0, 8'd10, DPI_HIGH);
      send_blob(10, 1'b0, 1'b0);
      wait_drained();
      set_config(8'd255, 8'd244, DPI_HIGH);
      send_blob(3, 1'b1, 1'b0);
      wait_drained();
      set_config(8'd0, 8'd255, DPI_HIGH);
      send_blob(3, 1'b1, 1'b0);
      wait_drained();
      // rejections: resolutions that select no group
      set_config(8'd20, 8'd20, 9'd0);
      send_blob(3, 1'b1, 1'b0);
      wait_drained();
      set_config(8'd20, 8'd20, 9'd511);
      send_blob(3, 1'b1, 1'b0);
      wait_drained();
      set_config(8'd20, 8'd20, 9'd359);
      send_blob(3, 1'b1, 1'b0);
      wait_drained();

      // largest negative difference, whole group 1
      set_config(8'd255, 8'd245, DPI_MID);
      send_blob(FULL_BLOB + GROUP_BYTES, 1'b1, 1'b0);
      wait_drained();

      // group 2 and an overlong blob: position holds past the limit
      set_config(8'd128, 8'd118, DPI_LOW);
      send_blob(int'(MEAS_BYTES) + 8, 1'b1, 1'b0);
      wait_drained();

      // settings changed inside one blob, picked up live
      set_config(8'd60, 8'd60, DPI_HIGH);
      send_blob(300, 1'b1, 1'b0);
      wait_drained();
      set_config(8'd60, 8'd60, DPI_LOW);      // position now outside group 2
      send_blob(50, 1'b0, 1'b0);
      wait_drained();
      set_config(8'd60, 8'd71, DPI_HIGH);     // difference out of range mid-blob
      send_blob(20, 1'b0, 1'b0);
      wait_drained();
      set_config(8'd60, 8'd65, DPI_HIGH);     // resumes into channel 1
      send_blob(600, 1'b0, 1'b0);
      wait_drained();

      // ---- random part, roles swapped ----
      send_idle_pct = 76;
      recv_idle_pct = 14;
      random_blobs(RANDOM_BYTES / 2);

      // ---- no idling; first a long hold-off so the block backs up ----
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(8'd100, 8'd105, DPI_HIGH);
      long_hold_due = 1'b1;
      send_blob(FULL_BLOB, 1'b1, 1'b0);
      random_blobs(RANDOM_BYTES);

      wait_drained();
      if (mismatch_count == 0 && bytes_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/ptcc_pkg.sv
hdl/ptcc_if.sv
hdl/ptcc_datapath.sv
hdl/ptcc_ctrl.sv
hdl/printhead_temp_calib_correct.sv
tb/sv/ptcc_table_checker.sv
tb/sv/printhead_temp_calib_correct_tb.sv
